FILE: hw/rtl/buddy_page_allocator_macros.svh
// Assertion macros for the buddy page allocator.
// No dependencies; included by the top level only.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define BPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buddy allocator assertion failed");
// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buddy allocator assertion failed");
`else
`define BPA_ASSERT_NOW(lbl, ante, cons)
`define BPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/bpa_pkg.sv
// Shared types, constants and codes of the buddy page allocator.
// No dependencies.
package bpa_pkg;

  localparam int PAGE_COUNT = 1024;
  localparam int MAX_ORDER  = 10;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_AW    = $clog2(PAGE_COUNT);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int LINK_W     = PAGE_AW + 1;
  localparam int ORD_W      = 4;
  localparam int KCALC_W    = 5;
  localparam int PAGES_W    = 32 - PAGE_SHIFT;

  localparam logic [LINK_W-1:0] LINK_EMPTY = '1;
  localparam logic [4:0]        ORDER_NONE = 5'd31;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_TOO_LARGE = 2'd1,
    RES_NO_SPACE  = 2'd2,
    RES_BAD_FREE  = 2'd3
  } bpa_res_t;

  typedef enum logic [1:0] {
    PS_FREE   = 2'd0,
    PS_ALLOC  = 2'd1,
    PS_INSIDE = 2'd2,
    PS_SPARE  = 2'd3
  } bpa_pstat_t;

  typedef struct packed {
    logic [4:0] order;
    bpa_pstat_t pstat;
  } bpa_info_t;

  typedef struct packed {
    logic        cmd;
    logic [30:0] request_bytes;
    logic [9:0]  page_index;
  } bpa_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] block_page;
    logic [3:0] block_order;
  } bpa_out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AFIND, S_APOP, S_ASPLIT, S_FCHK, S_BRD, S_BCHK,
    S_URD, S_UDATA, S_MERGE, S_PUSH, S_RESULT
  } bpa_state_t;

  typedef struct packed {
    logic     clr;
    logic     load;
    logic     find;
    logic     pop;
    logic     split;
    logic     fchk;
    logic     brd;
    logic     bchk;
    logic     urd;
    logic     udata;
    logic     merge;
    logic     push;
    logic     set_res;
    bpa_res_t res_code;
    logic     out_load;
  } bpa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic too_large;
    logic found;
    logic split_more;
    logic free_bad;
    logic ord_max;
    logic bud_ok;
    logic cur_empty;
    logic cur_is_bud;
  } bpa_stat_t;

endpackage

FILE: hw/rtl/buddy_page_allocator.sv
// Buddy page allocator over 1024 pages of 4 KiB, orders 0 to 10. After reset
// the block runs a clearing pass over all 1024 entries of its page RAMs and
// takes no request until it ends. An allocate finds a list, pops and splits;
// a free checks the page, then per merge level reads the buddy's info and walks
// the buddy's free list up to and including the buddy, as each link read
// goes through the single read port of the link RAM. One request is worked at
// a time; the result register lets the next request enter while a result waits.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath and the macro header.
`include "buddy_page_allocator_macros.svh"
module buddy_page_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  bpa_pkg::bpa_in_t req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output bpa_pkg::bpa_out_t rsp
);
  import bpa_pkg::*;

  bpa_cmd_t  cmd;
  bpa_stat_t st;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .st(st), .cmd(cmd)
  );

  bpa_datapath u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .st(st), .rsp(rsp)
  );

  `BPA_ASSERT_NOW(a_err_zero, rsp_valid && rsp.status != RES_OK, rsp.block_page == '0 && rsp.block_order == '0)
  `BPA_ASSERT_NOW(a_ord_range, rsp_valid, rsp.block_order <= 4'(MAX_ORDER))
  `BPA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
endmodule

FILE: hw/rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/bpa_ctrl.sv
// Sequencer of the buddy page allocator: steps alloc, free, merge and unlink.
// Depends on bpa_pkg.
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  bpa_pkg::bpa_stat_t st,
  output bpa_pkg::bpa_cmd_t  cmd
);
  import bpa_pkg::*;

  bpa_state_t state, state_next;
  logic       out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp_valid = out_valid;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = RES_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = 1'b1;
        if (req_valid) state_next = S_AFIND;
      end
      S_AFIND: begin
        if (st.is_free) begin
          state_next = S_FCHK;
        end else if (st.too_large) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = RES_TOO_LARGE;
          state_next   = S_RESULT;
        end else if (!st.found) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = RES_NO_SPACE;
          state_next   = S_RESULT;
        end else begin
          cmd.find   = 1'b1;
          state_next = S_APOP;
        end
      end
      S_APOP: begin
        cmd.pop    = 1'b1;
        state_next = S_ASPLIT;
      end
      S_ASPLIT: begin
        cmd.split = 1'b1;
        if (!st.split_more) begin
          cmd.set_res = 1'b1;
          state_next  = S_RESULT;
        end
      end
      S_FCHK: begin
        // info of the page was read in the previous state
        if (st.free_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = RES_BAD_FREE;
          state_next   = S_RESULT;
        end else begin
          cmd.fchk   = 1'b1;
          state_next = S_BRD;
        end
      end
      S_BRD: begin
        cmd.brd    = 1'b1;
        state_next = st.ord_max ? S_PUSH : S_BCHK;
      end
      S_BCHK: begin
        cmd.bchk   = 1'b1;
        state_next = st.bud_ok ? S_URD : S_PUSH;
      end
      S_URD: begin
        cmd.urd    = 1'b1;
        state_next = st.cur_empty ? S_MERGE : S_UDATA;
      end
      S_UDATA: begin
        cmd.udata  = 1'b1;
        state_next = st.cur_is_bud ? S_MERGE : S_URD;
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = S_BRD;
      end
      S_PUSH: begin
        cmd.push    = 1'b1;
        cmd.set_res = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: hw/rtl/bpa_datapath.sv
// Datapath of the buddy page allocator: list heads, link and page-info RAMs,
// walk pointers and the result register. Depends on bpa_pkg and bpa_ram.
module bpa_datapath (
  input  logic               clk,
  input  logic               rst,
  input  bpa_pkg::bpa_in_t   req,
  input  bpa_pkg::bpa_cmd_t  cmd,
  output bpa_pkg::bpa_stat_t st,
  output bpa_pkg::bpa_out_t  rsp
);
  import bpa_pkg::*;

  logic [LINK_W-1:0]  head [0:MAX_ORDER];
  logic [PAGE_AW-1:0] clr_addr;
  logic               is_free;
  logic [KCALC_W-1:0] k;
  logic [ORD_W-1:0]   t;
  logic [ORD_W-1:0]   ord;
  logic [PAGE_AW-1:0] pg;
  logic [LINK_W-1:0]  cur;
  logic [LINK_W-1:0]  prev;
  bpa_res_t           res_code;

  logic               info_we, link_we;
  logic [PAGE_AW-1:0] info_waddr, info_raddr, link_waddr, link_raddr;
  bpa_info_t          info_wdata, info_rdata;
  logic [LINK_W-1:0]  link_wdata, link_rdata;

  logic [31:0]        byte_sum;
  logic [PAGES_W-1:0] pages, pages_m1;
  logic [KCALC_W-1:0] kcalc;
  logic               found;
  logic [ORD_W-1:0]   ft;
  logic [ORD_W-1:0]   tn;
  logic [PAGE_AW-1:0] bud, lo, hi, right;

  bpa_ram #(.WIDTH($bits(bpa_info_t)), .DEPTH(PAGE_COUNT)) u_info (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(info_raddr), .rdata(info_rdata)
  );

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  // pages = ceil(bytes / PAGE_BYTES); order = bit length of pages - 1
  always_comb begin
    byte_sum = {1'b0, req.request_bytes} + 32'(PAGE_BYTES - 1);
    pages    = byte_sum[31:PAGE_SHIFT];
    pages_m1 = pages - PAGES_W'(1);
    kcalc    = '0;
    if (pages > PAGES_W'(1)) begin
      for (int i = 0; i < PAGES_W; i++) begin
        if (pages_m1[i]) kcalc = KCALC_W'(i + 1);
      end
    end
  end

  // lowest non-empty list at or above the requested order
  always_comb begin
    found = 1'b0;
    ft    = '0;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      if (!found && KCALC_W'(i) >= k && !head[i][LINK_W-1]) begin
        found = 1'b1;
        ft    = ORD_W'(i);
      end
    end
  end

  assign tn    = t - ORD_W'(1);
  assign right = pg | (PAGE_AW'(1) << tn);
  assign bud   = pg ^ (PAGE_AW'(1) << ord);
  assign lo    = pg & bud;
  assign hi    = pg | bud;

  always_comb begin
    st.clr_done   = (clr_addr == PAGE_AW'(PAGE_COUNT - 1));
    st.is_free    = is_free;
    st.too_large  = (k > KCALC_W'(MAX_ORDER));
    st.found      = found;
    st.split_more = (KCALC_W'(t) > k);
    st.free_bad   = (info_rdata.pstat != PS_ALLOC) || (info_rdata.order > 5'(MAX_ORDER));
    st.ord_max    = (ord == ORD_W'(MAX_ORDER));
    st.bud_ok     = (info_rdata.pstat == PS_FREE) && (info_rdata.order == 5'(ord));
    st.cur_empty  = cur[LINK_W-1];
    st.cur_is_bud = (cur == {1'b0, bud});
  end

  // RAM port steering
  always_comb begin
    info_we    = 1'b0;
    info_waddr = pg;
    info_wdata = '{order: 5'(ord), pstat: PS_FREE};
    info_raddr = pg;
    link_we    = 1'b0;
    link_waddr = pg;
    link_wdata = LINK_EMPTY;
    link_raddr = head[ft][PAGE_AW-1:0];
    if (cmd.clr) begin
      info_we    = 1'b1;
      info_waddr = clr_addr;
      info_wdata = (clr_addr == '0) ? '{order: 5'(MAX_ORDER), pstat: PS_FREE}
                                    : '{order: ORDER_NONE, pstat: PS_INSIDE};
      link_we    = 1'b1;
      link_waddr = clr_addr;
    end
    if (cmd.split) begin
      info_we = 1'b1;
      if (st.split_more) begin
        info_waddr = right;
        info_wdata = '{order: 5'(tn), pstat: PS_FREE};
        link_we    = 1'b1;
        link_waddr = right;
        link_wdata = head[tn];
      end else begin
        info_wdata = '{order: k, pstat: PS_ALLOC};
      end
    end
    if (cmd.brd) info_raddr = bud;
    if (cmd.urd) link_raddr = cur[PAGE_AW-1:0];
    if (cmd.udata && st.cur_is_bud && !prev[LINK_W-1]) begin
      link_we    = 1'b1;
      link_waddr = prev[PAGE_AW-1:0];
      link_wdata = link_rdata;
    end
    if (cmd.merge) begin
      info_we    = 1'b1;
      info_waddr = hi;
      info_wdata = '{order: ORDER_NONE, pstat: PS_INSIDE};
      link_we    = 1'b1;
      link_waddr = hi;
    end
    if (cmd.push) begin
      info_we    = 1'b1;
      link_we    = 1'b1;
      link_wdata = head[ord];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head[i] <= (i == MAX_ORDER) ? '0 : LINK_EMPTY;
      end
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + PAGE_AW'(1);
      if (cmd.pop) head[t] <= link_rdata;
      if (cmd.split && st.split_more) head[tn] <= {1'b0, right};
      if (cmd.udata && st.cur_is_bud && prev[LINK_W-1]) head[ord] <= link_rdata;
      if (cmd.push) head[ord] <= {1'b0, pg};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_free <= req.cmd;
      pg      <= req.page_index;
      k       <= kcalc;
      ord     <= kcalc[ORD_W-1:0];
    end
    if (cmd.find) begin
      t  <= ft;
      pg <= head[ft][PAGE_AW-1:0];
    end
    if (cmd.split && st.split_more) t <= tn;
    if (cmd.fchk) ord <= info_rdata.order[ORD_W-1:0];
    if (cmd.bchk) begin
      cur  <= head[ord];
      prev <= LINK_EMPTY;
    end
    if (cmd.udata && !st.cur_is_bud) begin
      prev <= cur;
      cur  <= link_rdata;
    end
    if (cmd.merge) begin
      pg  <= lo;
      ord <= ord + ORD_W'(1);
    end
    if (cmd.set_res) res_code <= cmd.res_code;
    if (cmd.out_load) begin
      rsp.status      <= res_code;
      rsp.block_page  <= (res_code == RES_OK) ? pg : '0;
      rsp.block_order <= (res_code == RES_OK) ? ord : '0;
    end
  end
endmodule
